// ----- sv/twab_pkg.sv -----
// ----------------------------------------------------------------------------
// twab_pkg
// Shared types and constants for the time-window average block.
// ----------------------------------------------------------------------------
`default_nettype none

package twab_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 8;
  localparam int PRICE_BITS  = 32;
  localparam int TIME_BITS   = 48;
  localparam int SUM_W       = PRICE_BITS + IDX_W;
  localparam int ENTRY_W     = PRICE_BITS + TIME_BITS;
  localparam int DIV_STEPS_W = $clog2(SUM_W + 1);

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_POST,
    ST_CHECK,
    ST_DROP,
    ST_APPEND,
    ST_SUM,
    ST_DIV,
    ST_MARK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [PRICE_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/twab_ram.sv -----
// ----------------------------------------------------------------------------
// twab_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module twab_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/twab_div.sv -----
// ----------------------------------------------------------------------------
// twab_div
// Restoring divider, one quotient bit per cycle, sum by entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module twab_div
  import twab_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                   busy_q, busy_d;
  logic [DIV_STEPS_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]       rem_q, rem_d;
  logic [SUM_W-1:0]       quo_q, quo_d;
  logic [CNT_W-1:0]       dvs_q, dvs_d;
  logic                   done_q, done_d;
  logic [CNT_W:0]         trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[SUM_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_STEPS_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[PRICE_BITS-1:0];

endmodule

`default_nettype wire

// ----- sv/time_window_average_bounded.sv -----
// ----------------------------------------------------------------------------
// time_window_average_bounded
// Sliding time-window average of timestamped prices over a bounded store.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. The time a sample takes grows with N, the
// entries held when it arrives, and is set by the single read port of the entry
// RAM, swept once each for expiry compaction (only when the sample time is above
// the window length), capacity drop (only when the count has reached the
// capacity), summing and the closest-entry search, plus the bit-serial divider
// (39 quotient bits). The result register lets the next sample be taken while a
// result waits. The first sample after reset only fills the store and is
// returned as its own average.
`default_nettype none

module time_window_average_bounded
  import twab_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // s_axis_tdata: sample_time[47:0], sample_price[79:48]
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,
  // m_axis_tdata: window_average[31:0], entry_count[39:32], window_sum[78:40],
  //               expired_count[86:79], capacity_drop[87]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [87:0]       m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]      bin_cap_q;
  logic [TIME_BITS-1:0]  window_q;

  logic [TIME_BITS-1:0]  t_q, t_d;
  logic [PRICE_BITS-1:0] p_q, p_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [PRICE_BITS-1:0] avg_q, avg_d;
  logic [IDX_W-1:0]      closest_q, closest_d;
  logic [PRICE_BITS-1:0] best_q, best_d;
  logic [CNT_W-1:0]      expired_q, expired_d;
  logic                  dropped_q, dropped_d;
  logic [CNT_W-1:0]      keep_q, keep_d;
  logic [TIME_BITS-1:0]  limit_q, limit_d;

  logic [CNT_W-1:0]      rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]      end_q, end_d;
  logic                  vld_q, vld_d;
  logic [IDX_W-1:0]      pidx_q, pidx_d;
  logic                  scan_done;

  logic                  out_vld_q, out_vld_d;
  logic [87:0]           out_q, out_d;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic [ENTRY_W-1:0]    mem_rdata;
  logic [PRICE_BITS-1:0] rd_price;
  logic [TIME_BITS-1:0]  rd_time;
  logic [PRICE_BITS-1:0] gap;
  logic [CNT_W-1:0]      cap;
  logic [CNT_W-1:0]      drop_pos;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[3] ? {{(64-TIME_BITS){1'b0}}, window_q}
                           : {{(64-CNT_W){1'b0}}, bin_cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cap_q <= CNT_W'(100);
      window_q  <= TIME_BITS'(1966080);
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        window_q <= pwdata[TIME_BITS-1:0];
      end else begin
        bin_cap_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  assign rd_price  = mem_rdata[PRICE_BITS-1:0];
  assign rd_time   = mem_rdata[ENTRY_W-1:PRICE_BITS];
  assign gap       = (rd_price >= avg_q) ? rd_price - avg_q : avg_q - rd_price;
  assign cap       = (bin_cap_q > MAX_COUNT) ? MAX_COUNT : bin_cap_q;
  assign drop_pos  = ({1'b0, closest_q} < count_q) ? {1'b0, closest_q} : count_q - 1'b1;
  assign scan_done = (rd_idx_q >= end_q) && !vld_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (count_q == '0) begin
            state_d = ST_DONE;
          end else if (s_axis_tdata[TIME_BITS-1:0] > window_q) begin
            state_d = ST_EXPIRE;
          end else begin
            state_d = ST_POST;
          end
        end
      end
      ST_EXPIRE: if (scan_done) state_d = ST_POST;
      ST_POST:   state_d = ST_CHECK;
      ST_CHECK:  state_d = (count_q >= cap) ? ST_DROP : ST_APPEND;
      ST_DROP:   if (scan_done) state_d = ST_APPEND;
      ST_APPEND: state_d = ST_SUM;
      ST_SUM:    if (scan_done) state_d = ST_DIV;
      ST_DIV:    if (div_rsp.done) state_d = ST_MARK;
      ST_MARK:   if (scan_done) state_d = ST_DONE;
      ST_DONE:   if (!out_vld_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    t_d       = t_q;
    p_d       = p_q;
    count_d   = count_q;
    sum_d     = sum_q;
    avg_d     = avg_q;
    closest_d = closest_q;
    best_d    = best_q;
    expired_d = expired_q;
    dropped_d = dropped_q;
    keep_d    = keep_q;
    limit_d   = limit_q;
    rd_idx_d  = rd_idx_q;
    end_d     = end_q;
    vld_d     = 1'b0;
    pidx_d    = rd_idx_q[IDX_W-1:0];
    out_vld_d = out_vld_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_wdata = {t_q, p_q};
    div_req   = '{start: 1'b0, dividend: sum_q, divisor: count_q};

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    if (state_q == ST_EXPIRE || state_q == ST_DROP ||
        state_q == ST_SUM || state_q == ST_MARK) begin
      if (rd_idx_q < end_q) begin
        rd_idx_d = rd_idx_q + 1'b1;
        vld_d    = 1'b1;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          t_d       = s_axis_tdata[TIME_BITS-1:0];
          p_d       = s_axis_tdata[ENTRY_W-1:TIME_BITS];
          expired_d = '0;
          dropped_d = '0;
          keep_d    = '0;
          rd_idx_d  = '0;
          end_d     = count_q;
          limit_d   = s_axis_tdata[TIME_BITS-1:0] - window_q;
          if (count_q == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {s_axis_tdata[TIME_BITS-1:0], s_axis_tdata[ENTRY_W-1:TIME_BITS]};
            count_d   = CNT_W'(1);
            sum_d     = SUM_W'(s_axis_tdata[ENTRY_W-1:TIME_BITS]);
            avg_d     = s_axis_tdata[ENTRY_W-1:TIME_BITS];
            closest_d = '0;
          end
        end
      end
      ST_EXPIRE: begin
        if (vld_q) begin
          if (rd_time < limit_q) begin
            expired_d = expired_q + 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = keep_q[IDX_W-1:0];
            mem_wdata = mem_rdata;
            keep_d    = keep_q + 1'b1;
          end
        end
        if (scan_done) begin
          count_d = keep_q;
        end
      end
      ST_POST: begin
        if (count_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = {t_q, avg_q};
          count_d   = CNT_W'(1);
        end
      end
      ST_CHECK: begin
        rd_idx_d = drop_pos + 1'b1;
        end_d    = count_q;
      end
      ST_DROP: begin
        if (vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_q - 1'b1;
          mem_wdata = mem_rdata;
        end
        if (scan_done) begin
          count_d   = count_q - 1'b1;
          dropped_d = 1'b1;
        end
      end
      ST_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = count_q[IDX_W-1:0];
        mem_wdata = {t_q, p_q};
        count_d   = count_q + 1'b1;
        sum_d     = '0;
        rd_idx_d  = '0;
        end_d     = count_q + 1'b1;
      end
      ST_SUM: begin
        if (vld_q) begin
          sum_d = sum_q + SUM_W'(rd_price);
        end
        if (scan_done) begin
          div_req.start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          avg_d     = div_rsp.quotient;
          best_d    = div_rsp.quotient;
          closest_d = '0;
          rd_idx_d  = '0;
          end_d     = count_q - 1'b1;
        end
      end
      ST_MARK: begin
        if (vld_q && gap < best_q) begin
          best_d    = gap;
          closest_d = pidx_q;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_d     = {dropped_q, expired_q, sum_q, count_q, avg_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      sum_q     <= '0;
      avg_q     <= '0;
      closest_q <= '0;
      out_vld_q <= 1'b0;
      vld_q     <= 1'b0;
      rd_idx_q  <= '0;
      end_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      avg_q     <= avg_d;
      closest_q <= closest_d;
      out_vld_q <= out_vld_d;
      vld_q     <= vld_d;
      rd_idx_q  <= rd_idx_d;
      end_q     <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    p_q       <= p_d;
    best_q    <= best_d;
    expired_q <= expired_d;
    dropped_q <= dropped_d;
    keep_q    <= keep_d;
    limit_q   <= limit_d;
    pidx_q    <= pidx_d;
    out_q     <= out_d;
  end

  twab_ram #(
    .Width (ENTRY_W),
    .Depth (MAX_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  twab_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_COUNT)
    else $error("entry count above store depth");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !vld_q)
    else $error("read pending while taking a request");

  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:32] != '0))
    else $error("result with empty store");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide phase");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded time-window average block.
// ----------------------------------------------------------------------------
// Samples go in on the slave stream and per-sample results come out on the
// master stream. A behavioral copy of the window store predicts each result.
// The bench steps through register settings and idling phases, and flags any
// unexpected, wrong or missing result.
`timescale 1ns / 1ps
`default_nettype none

module tb_top
  import twab_pkg::*;
();

  localparam logic [3:0] ADDR_CAPACITY = 4'd0;
  localparam logic [3:0] ADDR_WINDOW   = 4'd8;

  typedef struct packed {
    logic                  drop;
    logic [7:0]            expired;
    logic [SUM_W-1:0]      sum;
    logic [7:0]            count;
    logic [PRICE_BITS-1:0] average;
  } avg_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  time_window_average_bounded u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // window model state
  logic [PRICE_BITS-1:0] win_price [MAX_ENTRIES];
  logic [TIME_BITS-1:0]  win_time  [MAX_ENTRIES];
  int unsigned           win_count;
  logic [SUM_W-1:0]      win_sum;
  logic [PRICE_BITS-1:0] win_avg;
  int unsigned           win_mark;
  logic [7:0]            cfg_capacity;
  logic [TIME_BITS-1:0]  cfg_window;

  avg_result_t pending_results[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          recv_hold = 1'b0;

  function automatic void remark_nearest();
    logic [PRICE_BITS-1:0] best, gap;
    best = win_avg;
    win_mark = 0;
    for (int unsigned i = 0; i + 1 < win_count; i++) begin
      gap = (win_price[i] >= win_avg) ? win_price[i] - win_avg : win_avg - win_price[i];
      if (gap < best) begin
        best = gap;
        win_mark = i;
      end
    end
  endfunction

  function automatic avg_result_t predict_average(logic [TIME_BITS-1:0] t,
                                                  logic [PRICE_BITS-1:0] p);
    avg_result_t r;
    int unsigned keep, cap, pos;
    logic [TIME_BITS-1:0] lim;
    r = '0;
    if (win_count == 0) begin
      win_price[0] = p;
      win_time[0] = t;
      win_count = 1;
      win_sum = SUM_W'(p);
      win_avg = p;
    end else begin
      cap = (cfg_capacity > MAX_ENTRIES) ? MAX_ENTRIES : cfg_capacity;
      if (t > cfg_window) begin
        lim = t - cfg_window;
        keep = 0;
        for (int i = 0; i < win_count; i++) begin
          if (win_time[i] < lim) r.expired++;
          else begin
            win_price[keep] = win_price[i];
            win_time[keep] = win_time[i];
            keep++;
          end
        end
        win_count = keep;
      end
      if (win_count == 0) begin
        win_price[0] = win_avg;
        win_time[0] = t;
        win_count = 1;
      end
      if (win_count >= cap) begin
        pos = (win_mark < win_count) ? win_mark : win_count - 1;
        for (int unsigned i = pos; i + 1 < win_count; i++) begin
          win_price[i] = win_price[i+1];
          win_time[i] = win_time[i+1];
        end
        win_count--;
        r.drop = 1'b1;
      end
      if (win_count < MAX_ENTRIES) begin
        win_price[win_count] = p;
        win_time[win_count] = t;
        win_count++;
      end
      win_sum = '0;
      for (int i = 0; i < win_count; i++) win_sum += SUM_W'(win_price[i]);
      win_avg = PRICE_BITS'(win_sum / win_count);
    end
    remark_nearest();
    r.average = win_avg;
    r.count = 8'(win_count);
    r.sum = win_sum;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    avg_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) report_mismatch("unexpected result", 64'(got.sum), '0);
      else begin
        want = pending_results.pop_front();
        if (got.average !== want.average)
          report_mismatch("average", 64'(got.average), 64'(want.average));
        if (got.count !== want.count)
          report_mismatch("count", 64'(got.count), 64'(want.count));
        if (got.sum !== want.sum)
          report_mismatch("sum", 64'(got.sum), 64'(want.sum));
        if (got.expired !== want.expired)
          report_mismatch("expired", 64'(got.expired), 64'(want.expired));
        if (got.drop !== want.drop)
          report_mismatch("drop", 64'(got.drop), 64'(want.drop));
      end
    end
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [3:0] addr, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_CAPACITY) cfg_capacity = value[7:0];
    else cfg_window = value[TIME_BITS-1:0];
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic send_sample(logic [TIME_BITS-1:0] t, logic [PRICE_BITS-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.insert(pending_results.size(), predict_average(t, p));
  endtask

  // directed table: time, price, expected valid, expected (where obvious)
  typedef struct {
    logic [TIME_BITS-1:0]  t;
    logic [PRICE_BITS-1:0] p;
    bit                    known;
    avg_result_t           r;
  } sample_row_t;

  sample_row_t directed[] = '{
    '{48'd0, 32'hFFFF_FFFF, 1, '{1'b0, 8'd0, 39'hFFFF_FFFF, 8'd1, 32'hFFFF_FFFF}},
    '{48'd0, 32'd0, 1, '{1'b0, 8'd0, 39'hFFFF_FFFF, 8'd2, 32'h7FFF_FFFF}},
    '{48'd10, 32'h0001_0000, 0, '{default: '0}},
    '{48'd1966080, 32'h8000_0000, 0, '{default: '0}},
    '{48'h0000_FFFF_0000, 32'h1234_5678, 0, '{default: '0}},
    '{48'h0000_FFFF_0000, 32'h1234_5678, 0, '{default: '0}},
    '{48'hFFFF_FFFF_FFFF, 32'hAAAA_AAAA, 0, '{default: '0}},
    '{48'hFFFF_FFFF_FFFF, 32'h5555_5555, 0, '{default: '0}},
    '{48'hFFFF_FFFF_FFFF, 32'd7, 0, '{default: '0}}
  };

  logic [TIME_BITS-1:0] clock_now;

  task automatic random_phase(int n, logic [7:0] cap, logic [TIME_BITS-1:0] win);
    drain_results();
    write_reg(ADDR_CAPACITY, 64'(cap));
    write_reg(ADDR_WINDOW, 64'(win));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) clock_now = 48'({$urandom, $urandom});
      else clock_now += $urandom_range(3) == 0 ? 48'(win) : 48'($urandom_range(40000));
      send_sample(clock_now, $urandom_range(9) == 0 ? {$urandom_range(1) ? 32'hFFFF_FFFF : 32'd0}
                                                      : $urandom);
    end
  endtask

  initial begin
    cfg_capacity = 8'd100;
    cfg_window = 48'd1966080;
    win_count = 0; win_sum = '0; win_avg = '0; win_mark = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[k]) begin
      send_sample(directed[k].t, directed[k].p);
      if (directed[k].known && pending_results[$] !== directed[k].r)
        report_mismatch("directed row", 64'(k), '0);
    end
    // long receiver hold fills the block and stalls the input
    drain_results();
    fork
      begin
        recv_hold = 1'b1;
        repeat (2000) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 6; i++) send_sample(48'd2_000_000 + i, $urandom);
    clock_now = 48'd3_000_000;
    random_phase(400, 8'd1, 48'd0);
    random_phase(300, 8'd0, 48'hFFFF_FFFF_FFFF);
    send_idle_pct = 48;
    random_phase(400, 8'd128, 48'd200000);
    send_idle_pct = 0; recv_stall_pct = 48;
    random_phase(400, 8'd255, 48'd1966080);
    send_idle_pct = 17; recv_stall_pct = 17;
    random_phase(200, 8'd5, 48'd60000);
    random_phase(300, 8'(1 + $urandom_range(127)), 48'($urandom_range(500000)));
    drain_results();
    if (error_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/twab_pkg.sv
sv/twab_ram.sv
sv/twab_div.sv
sv/time_window_average_bounded.sv
tb/sv/tb_top.sv
